// File: sv/rmq_pkg.sv
// Shared types, constants and step functions for the rotation matrix to
// quaternion core. No dependencies; every other file imports this package.
`default_nettype none
package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int IN_W      = 16;
  localparam int OUT_W     = 16;
  // Differences and sums of two elements, negated when needed.
  localparam int D_W       = IN_W + 2;
  localparam int MAG_W     = IN_W + 1;
  // Signed width for the radicand sums, wide enough to hold ONE.
  localparam int BASE_W    = (IN_W > FRAC_BITS + 1) ? IN_W : FRAC_BITS + 1;
  localparam int RAD_W     = BASE_W + 3;
  localparam int RADU_W    = RAD_W - 1;
  // Square root operand is the radicand shifted up by FRAC_BITS.
  localparam int SQ_IN_W   = ((RADU_W + FRAC_BITS + 1) / 2) * 2;
  localparam int SQ_W      = SQ_IN_W / 2;
  localparam int DEN_W     = SQ_W + 1;
  localparam int NUM_W     = MAG_W + FRAC_BITS + 1;
  localparam int VAL_W     = NUM_W + 2;

  localparam logic signed [RAD_W-1:0] ONE = RAD_W'(1) << FRAC_BITS;
  localparam logic signed [VAL_W-1:0] SAT_MAX = VAL_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [VAL_W-1:0] SAT_MIN = -VAL_W'(1 << (OUT_W - 1));

  // Output component that carries the half root instead of a quotient.
  typedef enum logic [1:0] {SLOT_X, SLOT_Y, SLOT_Z, SLOT_W} slot_t;

  // One classified item: three dividends in lane order and the radicand.
  typedef struct packed {
    logic signed [D_W-1:0] d0;
    logic signed [D_W-1:0] d1;
    logic signed [D_W-1:0] d2;
    logic [RADU_W-1:0]     rad;
    slot_t                 hslot;
    logic                  hneg;
  } item_t;

  // Fields that ride alongside the square root pipeline.
  typedef struct packed {
    logic signed [D_W-1:0] d0;
    logic signed [D_W-1:0] d1;
    logic signed [D_W-1:0] d2;
    slot_t                 hslot;
    logic                  hneg;
  } side_t;

  // Fields that ride alongside the divider pipelines.
  typedef struct packed {
    logic [SQ_W-1:0] h;
    slot_t           hslot;
    logic            hneg;
  } tail_t;

  typedef struct packed {
    logic [SQ_IN_W-1:0] x;
    logic [SQ_W+1:0]    rem;
    logic [SQ_W-1:0]    root;
  } sq_stage_t;

  typedef struct packed {
    logic [NUM_W-1:0] n;
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [NUM_W-1:0] q;
    logic             neg;
  } div_stage_t;

  // One digit of the integer square root: two operand bits, one root bit.
  function automatic sq_stage_t sq_step(sq_stage_t s);
    sq_stage_t        r;
    logic [SQ_W+4:0]  acc;
    logic [SQ_W+4:0]  trial;
    acc   = {1'b0, s.rem, s.x[SQ_IN_W-1 -: 2]};
    trial = acc - {3'b000, s.root, 2'b01};
    r.x   = {s.x[SQ_IN_W-3:0], 2'b00};
    if (!trial[SQ_W+4]) begin
      r.rem  = trial[SQ_W+1:0];
      r.root = {s.root[SQ_W-2:0], 1'b1};
    end else begin
      r.rem  = acc[SQ_W+1:0];
      r.root = {s.root[SQ_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // One bit of restoring division.
  function automatic div_stage_t div_step(div_stage_t s);
    div_stage_t       r;
    logic [DEN_W:0]   sh;
    logic [DEN_W+1:0] diff;
    sh    = {s.rem, s.n[NUM_W-1]};
    diff  = {1'b0, sh} - {2'b00, s.den};
    r     = s;
    r.n   = {s.n[NUM_W-2:0], 1'b0};
    r.q   = {s.q[NUM_W-2:0], ~diff[DEN_W+1]};
    r.rem = diff[DEN_W+1] ? sh[DEN_W-1:0] : diff[DEN_W-1:0];
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(logic signed [VAL_W-1:0] v);
    logic [OUT_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[OUT_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[OUT_W-1:0];
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/rmq_front.sv
// Front end: takes a matrix, picks the branch and pivot, and forms the
// radicand and the three dividends. Depends on rmq_pkg.
`default_nettype none
module rmq_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       accept,
  input  wire logic signed [rmq_pkg::IN_W-1:0] m00,
  input  wire logic signed [rmq_pkg::IN_W-1:0] m01,
  input  wire logic signed [rmq_pkg::IN_W-1:0] m02,
  input  wire logic signed [rmq_pkg::IN_W-1:0] m10,
  input  wire logic signed [rmq_pkg::IN_W-1:0] m11,
  input  wire logic signed [rmq_pkg::IN_W-1:0] m12,
  input  wire logic signed [rmq_pkg::IN_W-1:0] m20,
  input  wire logic signed [rmq_pkg::IN_W-1:0] m21,
  input  wire logic signed [rmq_pkg::IN_W-1:0] m22,
  output rmq_pkg::item_t                  item,
  output logic                            item_valid
);
  import rmq_pkg::*;

  logic signed [RAD_W-1:0] e00, e11, e22, tr, rad_s;
  logic signed [D_W-1:0]   dx, dy, dz, dw;
  logic signed [D_W-1:0]   s01, s02, s12, t01, t12, t20;
  logic signed [IN_W-1:0]  mii;
  logic                    piv1, piv2;
  item_t                   item_next;

  // Diagonal sums and the pivot choice.
  assign e00  = RAD_W'(m00);
  assign e11  = RAD_W'(m11);
  assign e22  = RAD_W'(m22);
  assign tr   = e00 + e11 + e22;
  assign piv1 = m11 > m00;
  assign mii  = piv1 ? m11 : m00;
  assign piv2 = m22 > mii;

  // Off-diagonal sums and differences.
  assign s01 = D_W'(m01) + D_W'(m10);
  assign s02 = D_W'(m02) + D_W'(m20);
  assign s12 = D_W'(m12) + D_W'(m21);
  assign t01 = D_W'(m10) - D_W'(m01);
  assign t12 = D_W'(m12) - D_W'(m21);
  assign t20 = D_W'(m20) - D_W'(m02);

  // Branch selection; each output component gets its signed dividend.
  always_comb begin
    item_next.hneg  = 1'b0;
    item_next.hslot = SLOT_Y;
    dx = '0;
    dy = '0;
    dz = '0;
    dw = '0;
    if (tr > 0) begin
      item_next.hslot = SLOT_W;
      item_next.hneg  = 1'b1;
      dx    = t01;
      dy    = t12;
      dz    = t20;
      rad_s = tr + ONE;
    end else if (piv2) begin
      item_next.hslot = SLOT_X;
      item_next.hneg  = 1'b1;
      dy    = s02;
      dz    = s12;
      dw    = t01;
      rad_s = e22 - e00 - e11 + ONE;
    end else if (piv1) begin
      item_next.hslot = SLOT_Z;
      dx    = -s12;
      dy    = s01;
      dw    = -t20;
      rad_s = e11 - e22 - e00 + ONE;
    end else begin
      item_next.hslot = SLOT_Y;
      dx    = -s02;
      dz    = s01;
      dw    = -t12;
      rad_s = e00 - e11 - e22 + ONE;
    end
    // A radicand of zero or less becomes one LSB.
    item_next.rad = (rad_s <= 0) ? RADU_W'(1) : rad_s[RADU_W-1:0];
    // Lanes carry the components other than the half root, in order.
    item_next.d0 = (item_next.hslot == SLOT_X) ? dy : dx;
    item_next.d1 = (item_next.hslot == SLOT_X || item_next.hslot == SLOT_Y) ? dz : dy;
    item_next.d2 = (item_next.hslot == SLOT_W) ? dz : dw;
  end

  // Output register of the front end.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= accept;
    end
    if (accept) begin
      item <= item_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/rmq_div.sv
// Pipelined rounding divider: |d| * 2^FRAC_BITS + sq over 2 * sq, one
// quotient bit per stage, sign kept aside. Depends on rmq_pkg.
`default_nettype none
module rmq_div (
  input  wire logic                             clk,
  input  wire logic signed [rmq_pkg::D_W-1:0]   d,
  input  wire logic [rmq_pkg::SQ_W-1:0]         sq,
  output logic [rmq_pkg::NUM_W-1:0]             q,
  output logic                                  neg
);
  import rmq_pkg::*;

  div_stage_t           st [NUM_W];
  div_stage_t           init;
  logic [MAG_W-1:0]     mag;
  logic signed [D_W-1:0] negd;

  // Magnitude, rounded numerator and doubled root.
  assign negd = -d;
  assign mag  = d[D_W-1] ? negd[MAG_W-1:0] : d[MAG_W-1:0];
  always_comb begin
    init.n   = (NUM_W'(mag) << FRAC_BITS) + NUM_W'(sq);
    init.rem = '0;
    init.den = {sq, 1'b0};
    init.q   = '0;
    init.neg = d[D_W-1];
  end

  // Division stages.
  always_ff @(posedge clk) begin
    st[0] <= div_step(init);
    for (int s = 1; s < NUM_W; s++) begin
      st[s] <= div_step(st[s-1]);
    end
  end

  assign q   = st[NUM_W-1].q;
  assign neg = st[NUM_W-1].neg;

endmodule
`default_nettype wire

// File: sv/rmq_back.sv
// Back end: square root pipeline, three divider lanes, remap and
// saturation into the output register. Depends on rmq_pkg and rmq_div.
`default_nettype none
module rmq_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  input  wire rmq_pkg::item_t          in_item,
  output logic                         done,
  output logic [rmq_pkg::OUT_W-1:0]    quat_x,
  output logic [rmq_pkg::OUT_W-1:0]    quat_y,
  output logic [rmq_pkg::OUT_W-1:0]    quat_z,
  output logic [rmq_pkg::OUT_W-1:0]    quat_w
);
  import rmq_pkg::*;

  sq_stage_t           sqs [SQ_W];
  side_t               sb  [SQ_W];
  logic [SQ_W-1:0]     sv;
  tail_t               tl  [NUM_W];
  logic [NUM_W-1:0]    tv;
  sq_stage_t           sq_init;
  side_t               side_in;
  tail_t               tail_in;
  logic [SQ_W-1:0]     root;
  logic [SQ_W:0]       root_inc;
  logic [NUM_W-1:0]    lq  [3];
  logic [2:0]          lneg;
  logic signed [VAL_W-1:0] lane_v [3];
  logic signed [VAL_W-1:0] hv;
  logic signed [VAL_W-1:0] ov [4];
  tail_t               tf;

  // Square root operand and the fields that travel with it.
  always_comb begin
    sq_init.x    = SQ_IN_W'({in_item.rad, {FRAC_BITS{1'b0}}});
    sq_init.rem  = '0;
    sq_init.root = '0;
    side_in.d0    = in_item.d0;
    side_in.d1    = in_item.d1;
    side_in.d2    = in_item.d2;
    side_in.hslot = in_item.hslot;
    side_in.hneg  = in_item.hneg;
  end

  // Square root stages with their side fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
    end else begin
      sv <= {sv[SQ_W-2:0], in_valid};
    end
    sqs[0] <= sq_step(sq_init);
    sb[0]  <= side_in;
    for (int s = 1; s < SQ_W; s++) begin
      sqs[s] <= sq_step(sqs[s-1]);
      sb[s]  <= sb[s-1];
    end
  end

  assign root     = sqs[SQ_W-1].root;
  assign root_inc = {1'b0, root} + (SQ_W+1)'(1);

  // Divider lanes.
  rmq_div u_div0 (.clk(clk), .d(sb[SQ_W-1].d0), .sq(root), .q(lq[0]), .neg(lneg[0]));
  rmq_div u_div1 (.clk(clk), .d(sb[SQ_W-1].d1), .sq(root), .q(lq[1]), .neg(lneg[1]));
  rmq_div u_div2 (.clk(clk), .d(sb[SQ_W-1].d2), .sq(root), .q(lq[2]), .neg(lneg[2]));

  // Half root and remap fields wait for the dividers.
  always_comb begin
    tail_in.h     = root_inc[SQ_W:1];
    tail_in.hslot = sb[SQ_W-1].hslot;
    tail_in.hneg  = sb[SQ_W-1].hneg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tv <= '0;
    end else begin
      tv <= {tv[NUM_W-2:0], sv[SQ_W-1]};
    end
    tl[0] <= tail_in;
    for (int s = 1; s < NUM_W; s++) begin
      tl[s] <= tl[s-1];
    end
  end

  // Signed lane values and the component remap.
  always_comb begin
    tf = tl[NUM_W-1];
    for (int l = 0; l < 3; l++) begin
      lane_v[l] = lneg[l] ? -$signed({2'b00, lq[l]}) : $signed({2'b00, lq[l]});
    end
    hv = $signed({{(VAL_W-SQ_W){1'b0}}, tf.h});
    if (tf.hneg) begin
      hv = -hv;
    end
    ov[0] = (tf.hslot == SLOT_X) ? hv : lane_v[0];
    ov[1] = (tf.hslot == SLOT_Y) ? hv : ((tf.hslot == SLOT_X) ? lane_v[0] : lane_v[1]);
    ov[2] = (tf.hslot == SLOT_Z) ? hv :
            ((tf.hslot == SLOT_X || tf.hslot == SLOT_Y) ? lane_v[1] : lane_v[2]);
    ov[3] = (tf.hslot == SLOT_W) ? hv : lane_v[2];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tv[NUM_W-1];
    end
    quat_x <= sat_out(ov[0]);
    quat_y <= sat_out(ov[1]);
    quat_z <= sat_out(ov[2]);
    quat_w <= sat_out(ov[3]);
  end

endmodule
`default_nettype wire

// File: sv/rotation_matrix_to_quaternion_core.sv
// Throughput: one matrix per clock cycle while busy is low, set by the fully pipelined square
// root (one root bit per stage) and the three pipelined dividers.
// Path to done: front register, queue, square root stages, divider stages and the
// output register; the receiver cannot stall.
// Reset (rst, synchronous) clears the queue and all valid flags; no memory
// needs clearing.
`default_nettype none
module rotation_matrix_to_quaternion_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic signed [rmq_pkg::IN_W-1:0] m00,
  input  wire logic signed [rmq_pkg::IN_W-1:0] m01,
  input  wire logic signed [rmq_pkg::IN_W-1:0] m02,
  input  wire logic signed [rmq_pkg::IN_W-1:0] m10,
  input  wire logic signed [rmq_pkg::IN_W-1:0] m11,
  input  wire logic signed [rmq_pkg::IN_W-1:0] m12,
  input  wire logic signed [rmq_pkg::IN_W-1:0] m20,
  input  wire logic signed [rmq_pkg::IN_W-1:0] m21,
  input  wire logic signed [rmq_pkg::IN_W-1:0] m22,
  output logic                                 done,
  output logic [rmq_pkg::OUT_W-1:0]            quat_x,
  output logic [rmq_pkg::OUT_W-1:0]            quat_y,
  output logic [rmq_pkg::OUT_W-1:0]            quat_z,
  output logic [rmq_pkg::OUT_W-1:0]            quat_w
);
  import rmq_pkg::*;

  item_t       fr_item;
  logic        fr_valid;
  item_t       qmem [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;
  logic        push, pop, accept;

  assign accept = start && !busy;

  rmq_front u_front (
    .clk(clk), .rst(rst), .accept(accept),
    .m00(m00), .m01(m01), .m02(m02),
    .m10(m10), .m11(m11), .m12(m12),
    .m20(m20), .m21(m21), .m22(m22),
    .item(fr_item), .item_valid(fr_valid)
  );

  // Two-entry queue between the front and back ends.
  assign push = fr_valid;
  assign pop  = (count != 2'd0);
  assign busy = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) begin
      qmem[wr_ptr] <= fr_item;
    end
  end

  rmq_back u_back (
    .clk(clk), .rst(rst), .in_valid(pop), .in_item(qmem[rd_ptr]),
    .done(done), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w)
  );

`ifndef SYNTHESIS
  // The queue never takes a transfer while it is full and not being read.
  assert property (@(posedge clk) disable iff (rst) !(push && count == 2'd2 && !pop))
    else $error("queue overflow");
  // The fill count stays within the queue depth.
  assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  // A transfer into an empty queue leaves exactly one entry.
  assert property (@(posedge clk) disable iff (rst) (count == 2'd0 && push) |=> count == 2'd1)
    else $error("queue count did not advance");
  // No result is shown right after reset.
  assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("result strobe after reset");
`endif

endmodule
`default_nettype wire

// File: tb/rotation_matrix_to_quaternion_core_tb.sv
// Self-checking testbench for the rotation matrix to quaternion core.
// Depends on rmq_pkg and rotation_matrix_to_quaternion_core; a local model
// predicts each quaternion and a monitor compares it with the done transfer.
`default_nettype none
module rotation_matrix_to_quaternion_core_tb;
  import rmq_pkg::*;

  typedef logic signed [IN_W-1:0] elem_t;
  typedef struct packed {
    elem_t a00, a01, a02, a10, a11, a12, a20, a21, a22;
  } matrix_t;
  typedef struct packed {
    logic [OUT_W-1:0] qx, qy, qz, qw;
  } quat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  matrix_t drv_mat = '0;
  logic [OUT_W-1:0] quat_x, quat_y, quat_z, quat_w;

  matrix_t pending_mats[$];
  quat_t   expected_quats[$];
  int      idle_pct = 0;
  bit      hold_off = 1'b0;
  int      errors = 0;

  rotation_matrix_to_quaternion_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .m00(drv_mat.a00), .m01(drv_mat.a01), .m02(drv_mat.a02),
    .m10(drv_mat.a10), .m11(drv_mat.a11), .m12(drv_mat.a12),
    .m20(drv_mat.a20), .m21(drv_mat.a21), .m22(drv_mat.a22),
    .done(done), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w)
  );

  // Clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Integer square root, bit by bit.
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Divide by twice the root, rounding ties away from zero.
  function automatic longint scaled_quot(longint d, longint sq);
    longint mag;
    mag = (d < 0) ? -d : d;
    mag = ((mag <<< FRAC_BITS) + sq) / (2 * sq);
    return (d < 0) ? -mag : mag;
  endfunction

  function automatic logic [OUT_W-1:0] clip16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[OUT_W-1:0];
  endfunction

  // Quaternion prediction with the core's axis remap and sign flips.
  function automatic quat_t predict_quat(matrix_t mt);
    longint m[3][3];
    longint tr, rad, sq, t[4];
    longint qx, qy, qz, qw;
    int i, j, k;
    quat_t q;
    m[0][0] = mt.a00; m[0][1] = mt.a01; m[0][2] = mt.a02;
    m[1][0] = mt.a10; m[1][1] = mt.a11; m[1][2] = mt.a12;
    m[2][0] = mt.a20; m[2][1] = mt.a21; m[2][2] = mt.a22;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      rad = tr + (64'sd1 <<< FRAC_BITS);
      sq = int_sqrt(rad << FRAC_BITS);
      qw = -((sq + 1) >> 1);
      qy = scaled_quot(m[1][2] - m[2][1], sq);
      qz = scaled_quot(m[2][0] - m[0][2], sq);
      qx = -scaled_quot(m[0][1] - m[1][0], sq);
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      rad = m[i][i] - m[j][j] - m[k][k] + (64'sd1 <<< FRAC_BITS);
      // A radicand of zero or below is clamped to one LSB.
      if (rad <= 0) rad = 1;
      sq = int_sqrt(rad << FRAC_BITS);
      t[i] = (sq + 1) >> 1;
      t[3] = scaled_quot(m[j][k] - m[k][j], sq);
      t[j] = scaled_quot(m[i][j] + m[j][i], sq);
      t[k] = scaled_quot(m[i][k] + m[k][i], sq);
      qy = t[0]; qz = t[1]; qx = -t[2]; qw = -t[3];
    end
    q.qx = clip16(qx); q.qy = clip16(qy); q.qz = clip16(qz); q.qw = clip16(qw);
    return q;
  endfunction

  function automatic elem_t rand_elem();
    case ($urandom_range(0, 5))
      0: return -16384;
      1: return 16384;
      2: return $urandom_range(0, 1) ? elem_t'($urandom) : elem_t'($urandom_range(0, 32)
                                                                     - 16);
      default: return elem_t'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // Random matrices; one in three is a near-rotation: scaled axis permutation with random noise.
  function automatic matrix_t rand_matrix();
    matrix_t mt;
    elem_t v[9];
    int p, s;
    for (int n = 0; n < 9; n++) v[n] = rand_elem();
    if ($urandom_range(0, 2) == 0) begin
      p = $urandom_range(0, 2);
      for (int r = 0; r < 3; r++) begin
        s = $urandom_range(0, 1) ? 16384 : -16384;
        v[r * 3 + (r + p) % 3] = elem_t'(s - int'($urandom_range(0, 400)) * (s / 16384));
      end
    end
    mt = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
    return mt;
  endfunction

  // Appends one matrix to the pending items.
  task automatic queue_matrix(matrix_t mt);
    pending_mats.insert(pending_mats.size(), mt);
  endtask

  // Transfer is decided at the rising edge; inputs update at the falling edge.
  bit taken = 1'b0;
  always @(posedge clk) begin
    taken <= !rst && start && !busy;
    if (!rst && start && !busy) begin
      expected_quats.insert(expected_quats.size(), predict_quat(drv_mat));
    end
  end

  // Driver: retires the accepted item and presents the next one unless idling.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (taken && pending_mats.size() > 0) void'(pending_mats.pop_front());
      if (!start || taken) begin
        if (pending_mats.size() > 0 && !hold_off &&
            $urandom_range(0, 99) >= idle_pct) begin
          drv_mat <= pending_mats[0];
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each done transfer with the oldest prediction.
  always @(posedge clk) begin
    quat_t want;
    if (!rst && done) begin
      if (expected_quats.size() == 0) begin
        $display("%0t: quaternion with none expected: %h %h %h %h", $time,
                 quat_x, quat_y, quat_z, quat_w);
        errors++;
      end else begin
        want = expected_quats.pop_front();
        if ({quat_x, quat_y, quat_z, quat_w} !== want) begin
          $display("%0t: mismatch expected x=%h y=%h z=%h w=%h actual x=%h y=%h z=%h w=%h",
                   $time, want.qx, want.qy, want.qz, want.qw,
                   quat_x, quat_y, quat_z, quat_w);
          errors++;
        end
      end
    end
  end

  task automatic drain();
    while (pending_mats.size() > 0 || start) @(posedge clk);
    while (expected_quats.size() > 0) @(posedge clk);
  endtask

  // Stimulus: directed corners, then random phases with varying idle rates.
  initial begin
    matrix_t mt;
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    queue_matrix('0);
    queue_matrix({16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                  16'sd0, 16'sd0, 16'sd16384});
    queue_matrix({-16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
                  16'sd0, 16'sd0, 16'sd16384});
    queue_matrix({-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                  16'sd0, 16'sd0, -16'sd16384});
    queue_matrix({16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
                  16'sd0, 16'sd0, -16'sd16384});
    // Strongly negative diagonal with equal elements; the radicand is not clamped.
    queue_matrix({-16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384,
                  -16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384,
                  -16'sd16384});
    // Large off-diagonal terms with a trace of zero.
    queue_matrix({16'sd1, 16'sd16384, -16'sd16384, -16'sd16384, 16'sd0,
                  16'sd16384, 16'sd16384, -16'sd16384, -16'sd1});
    queue_matrix({16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                  16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
    queue_matrix({16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                  16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
    queue_matrix({16'shffff, 16'shffff, 16'shffff, 16'shffff, 16'shffff,
                  16'shffff, 16'shffff, 16'shffff, 16'shffff});
    queue_matrix({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                  16'sd0, 16'sd1});
    // Ties between diagonal elements pick the lower pivot.
    queue_matrix({-16'sd100, 16'sd50, 16'sd3, -16'sd7, -16'sd100, 16'sd9,
                  16'sd11, -16'sd13, -16'sd100});
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 85 : (ph == 2) ? 26 : 50;
      for (int n = 0; n < 150; n++) begin
        mt = rand_matrix();
        queue_matrix(mt);
      end
      drain();
      // After the second phase, hold the driver off with hold_off, then resume.
      if (ph == 1) begin
        hold_off = 1'b1;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
    end
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_quats.size() == 0) begin
      $display("rotation_matrix_to_quaternion_core_tb OK");
    end else begin
      $display("rotation_matrix_to_quaternion_core_tb NOT OK");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("rotation_matrix_to_quaternion_core_tb NOT OK");
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
sv/rmq_pkg.sv
sv/rmq_front.sv
sv/rmq_div.sv
sv/rmq_back.sv
sv/rotation_matrix_to_quaternion_core.sv
tb/rotation_matrix_to_quaternion_core_tb.sv
